// ----- src/assert_macros.svh -----
// Assertion macros for the RTL modules of the depthwise convolution block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside of reset.
`define DCBR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next cycle.
`define DCBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DCBR_ASSERT(lbl, clk, rstn, prop, msg)
`define DCBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- src/dcbr_pkg.sv -----
// Shared types, constants and helper functions of the depthwise convolution block.
// No dependencies; imported by the controller, the datapath and the top level.
package dcbr_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_KERNEL = 7;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int LINE_ROWS  = MAX_KERNEL - 1;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + $clog2(NUM_TAPS);
    localparam int POS_W      = 8;
    localparam int DIM_W      = 9;
    localparam int K_W        = 3;
    localparam int TAP_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int DIV_CNT_W  = $clog2(POS_W);

    // Input commands.
    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_PIXEL  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_KERNEL_W  = 3'd2,
        REG_KERNEL_H  = 3'd3,
        REG_STRIDE_W  = 3'd4,
        REG_STRIDE_H  = 3'd5,
        REG_FUSE_BIAS = 3'd6,
        REG_FUSE_RELU = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [TAP_W-1:0]        tap_index;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         out_col;
        logic [POS_W-1:0]         out_row;
        logic                     saturated;
        logic                     last_of_plane;
    } out_item_t;

    // Geometry after clamping to the supported range.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [K_W-1:0]   kw;
        logic [K_W-1:0]   kh;
        logic [K_W-1:0]   sw;
        logic [K_W-1:0]   sh;
        logic             fuse_bias;
        logic             fuse_relu;
    } geom_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_pixel;
        logic load_tap;
        logic load_bias;
        logic mem_rd;
        logic shift;
        logic div_start;
        logic div_step;
        logic mac_start;
        logic mac_issue;
        logic post;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic geom_ok;
        logic rem_zero;
        logic mac_last;
    } ctrl_stat_t;

    // Image dimension: zero acts as one, values above the maximum saturate.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // Kernel size or stride: zero acts as one, values above the maximum saturate.
    function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] v,
                                               input logic [K_W-1:0] hi);
        logic [K_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = K_W'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ----- src/dcbr_ctrl.sv -----
// Controller state machine of the depthwise convolution block.
// Depends on dcbr_pkg and assert_macros.svh; drives the datapath commands.
`include "assert_macros.svh"

module dcbr_ctrl
    import dcbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    output logic       m_valid,
    input  logic       m_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_DIV,
        ST_CHECK,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_POST,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_t'(s_command))
                        CMD_WEIGHT: cmd.load_tap  = 1'b1;
                        CMD_BIAS:   cmd.load_bias = 1'b1;
                        CMD_PIXEL: begin
                            cmd.cap_pixel = 1'b1;
                            state_next    = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift     = 1'b1;
                cmd.div_start = 1'b1;
                div_cnt_next  = '0;
                state_next    = stat.geom_ok ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(POS_W - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.rem_zero) begin
                    cmd.mac_start = 1'b1;
                    state_next    = ST_MAC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (stat.mac_last) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_POST;
            ST_POST: begin
                cmd.post   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid flag follows the output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `DCBR_ASSERT(a_load_free, aclk, aresetn, cmd.out_load |-> out_free, "output overwritten")
    `DCBR_ASSERT(a_mac_entry, aclk, aresetn, (state_reg == ST_MAC && $past(state_reg) != ST_MAC) |-> $past(state_reg) == ST_CHECK, "MAC entered out of order")
    `DCBR_ASSERT_NEXT(a_post_fin, aclk, aresetn, state_reg == ST_POST, state_reg == ST_FIN, "result not staged after post")
    `DCBR_ASSERT(a_busy_stall, aclk, aresetn, (state_reg != ST_IDLE) |-> !(cmd.cap_pixel || cmd.load_tap || cmd.load_bias), "request taken while busy")

endmodule

// ----- src/dcbr_datapath.sv -----
// Datapath of the depthwise convolution block: line memory, window, taps, MAC and post.
// Depends on dcbr_pkg; driven by commands from dcbr_ctrl.
module dcbr_datapath
    import dcbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  geom_t      geom,
    input  in_item_t   s_data,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat,
    output out_item_t  m_data
);

    localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] RES_MIN = -ACC_W'(32768);

    // Position counters and the captured pixel.
    logic [POS_W-1:0]          col_reg, row_reg;
    logic [POS_W-1:0]          pc_reg, pr_reg;
    logic signed [DATA_W-1:0]  pix_reg;
    logic signed [DATA_W-1:0]  bias_reg;

    // Line memory: one word holds all buffered rows of one column.
    logic [LINE_ROWS*DATA_W-1:0] lmem [0:MAX_WIDTH-1];
    logic [LINE_ROWS*DATA_W-1:0] lrd_reg;
    logic signed [DATA_W-1:0]    lanes [0:LINE_ROWS-1];
    logic signed [DATA_W-1:0]    column [0:MAX_KERNEL-1];

    logic signed [DATA_W-1:0] win_reg [0:MAX_KERNEL-1][0:MAX_KERNEL-1];

    // Tap weight memory with valid bits.
    logic signed [DATA_W-1:0] tmem [0:NUM_TAPS-1];
    logic [NUM_TAPS-1:0]      tvalid_reg;

    // Dividers for output position and stride alignment.
    logic [POS_W-1:0] qc_reg, qr_reg;
    logic [K_W-1:0]   rc_reg, rr_reg;
    logic [K_W:0]     tc, tr;
    logic [POS_W:0]   xc_full, xr_full;

    // MAC pipeline.
    logic [K_W-1:0]            mi_reg, ni_reg;
    logic [TAP_W-1:0]          ti_reg;
    logic [K_W-1:0]            nidx;
    logic signed [DATA_W-1:0]  rd_w_reg, rd_p_reg;
    logic                      iss_v_reg, prod_v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // Post processing.
    logic signed [ACC_W-1:0] bias_term, sum, shifted;
    logic                    last_c, last_r;
    logic [POS_W+1:0]        pc1, pr1;
    out_item_t               res_reg, m_data_reg;

    // Pixel capture, position counters and bias.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            bias_reg <= '0;
        end else begin
            if (cmd.load_bias) begin
                bias_reg <= s_data.value;
            end
            if (cmd.cap_pixel) begin
                if ({1'b0, col_reg} + DIM_W'(1) >= geom.w) begin
                    col_reg <= '0;
                    if ({1'b0, row_reg} + DIM_W'(1) >= geom.h) begin
                        row_reg <= '0;
                    end else begin
                        row_reg <= row_reg + POS_W'(1);
                    end
                end else begin
                    col_reg <= col_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_pixel) begin
            pix_reg <= s_data.value;
            pc_reg  <= col_reg;
            pr_reg  <= row_reg;
        end
    end

    // Line memory read and shifted write back.
    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            lrd_reg <= lmem[pc_reg];
        end
        if (cmd.shift) begin
            lmem[pc_reg] <= {lrd_reg[(LINE_ROWS-1)*DATA_W-1:0], pix_reg};
        end
    end

    // New window column, top row first.
    always_comb begin
        for (int k = 0; k < LINE_ROWS; k++) begin
            lanes[k] = lrd_reg[k*DATA_W +: DATA_W];
        end
        for (int m = 0; m < MAX_KERNEL; m++) begin
            if (m + 1 < int'(geom.kh)) begin
                column[m] = lanes[K_W'(geom.kh - K_W'(2) - K_W'(m))];
            end else if (m + 1 == int'(geom.kh)) begin
                column[m] = pix_reg;
            end else begin
                column[m] = '0;
            end
        end
    end

    // Window shift register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < MAX_KERNEL; m++) begin
                for (int n = 0; n < MAX_KERNEL; n++) begin
                    win_reg[m][n] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int m = 0; m < MAX_KERNEL; m++) begin
                for (int n = 0; n < MAX_KERNEL - 1; n++) begin
                    win_reg[m][n] <= win_reg[m][n+1];
                end
                win_reg[m][MAX_KERNEL-1] <= column[m];
            end
        end
    end

    // Tap memory: written by weight loads, read once per MAC step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= '0;
        end else if (cmd.load_tap && s_data.tap_index < TAP_W'(NUM_TAPS)) begin
            tvalid_reg[s_data.tap_index] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_tap && s_data.tap_index < TAP_W'(NUM_TAPS)) begin
            tmem[s_data.tap_index] <= s_data.value;
        end
        if (cmd.mac_issue) begin
            rd_w_reg <= tvalid_reg[ti_reg] ? tmem[ti_reg] : '0;
        end
    end

    // Restoring dividers, one quotient bit per step.
    assign xc_full = {1'b0, pc_reg} + (POS_W+1)'(1) - (POS_W+1)'(geom.kw);
    assign xr_full = {1'b0, pr_reg} + (POS_W+1)'(1) - (POS_W+1)'(geom.kh);
    assign tc      = {rc_reg, qc_reg[POS_W-1]};
    assign tr      = {rr_reg, qr_reg[POS_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qc_reg <= xc_full[POS_W-1:0];
            qr_reg <= xr_full[POS_W-1:0];
            rc_reg <= '0;
            rr_reg <= '0;
        end else if (cmd.div_step) begin
            if (tc >= {1'b0, geom.sw}) begin
                rc_reg <= K_W'(tc - {1'b0, geom.sw});
                qc_reg <= {qc_reg[POS_W-2:0], 1'b1};
            end else begin
                rc_reg <= tc[K_W-1:0];
                qc_reg <= {qc_reg[POS_W-2:0], 1'b0};
            end
            if (tr >= {1'b0, geom.sh}) begin
                rr_reg <= K_W'(tr - {1'b0, geom.sh});
                qr_reg <= {qr_reg[POS_W-2:0], 1'b1};
            end else begin
                rr_reg <= tr[K_W-1:0];
                qr_reg <= {qr_reg[POS_W-2:0], 1'b0};
            end
        end
    end

    // MAC tap counters and window read.
    assign nidx = K_W'(K_W'(MAX_KERNEL) - geom.kw + ni_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mac_start) begin
            mi_reg <= '0;
            ni_reg <= '0;
            ti_reg <= '0;
        end else if (cmd.mac_issue) begin
            ti_reg <= ti_reg + TAP_W'(1);
            if (ni_reg == geom.kw - K_W'(1)) begin
                ni_reg <= '0;
                mi_reg <= mi_reg + K_W'(1);
            end else begin
                ni_reg <= ni_reg + K_W'(1);
            end
        end
        if (cmd.mac_issue) begin
            rd_p_reg <= win_reg[mi_reg][nidx];
        end
        prod_reg <= rd_p_reg * rd_w_reg;
    end

    // Accumulator behind the product register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            iss_v_reg  <= cmd.mac_issue;
            prod_v_reg <= iss_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_start) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Bias, ReLU, floor shift and saturation.
    assign pc1 = (POS_W+2)'(pc_reg) + (POS_W+2)'(1);
    assign pr1 = (POS_W+2)'(pr_reg) + (POS_W+2)'(1);

    always_comb begin
        bias_term = geom.fuse_bias ? (ACC_W'(bias_reg) <<< FRAC_BITS) : '0;
        sum       = acc_reg + bias_term;
        if (geom.fuse_relu && sum < 0) begin
            sum = '0;
        end
        shifted = sum >>> FRAC_BITS;
        last_c  = (pc1 <= (POS_W+2)'(geom.w)) &&
                  (pc1 + (POS_W+2)'(geom.sw) > (POS_W+2)'(geom.w));
        last_r  = (pr1 <= (POS_W+2)'(geom.h)) &&
                  (pr1 + (POS_W+2)'(geom.sh) > (POS_W+2)'(geom.h));
    end

    always_ff @(posedge aclk) begin
        if (cmd.post) begin
            if (shifted > RES_MAX) begin
                res_reg.result_value <= DATA_W'(RES_MAX);
                res_reg.saturated    <= 1'b1;
            end else if (shifted < RES_MIN) begin
                res_reg.result_value <= DATA_W'(RES_MIN);
                res_reg.saturated    <= 1'b1;
            end else begin
                res_reg.result_value <= DATA_W'(shifted);
                res_reg.saturated    <= 1'b0;
            end
            res_reg.out_col       <= qc_reg;
            res_reg.out_row       <= qr_reg;
            res_reg.last_of_plane <= last_c && last_r;
        end
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
    end

    // Status to the controller.
    assign stat.geom_ok  = ({1'b0, pc_reg} + (POS_W+1)'(1) >= (POS_W+1)'(geom.kw)) &&
                           ({1'b0, pr_reg} + (POS_W+1)'(1) >= (POS_W+1)'(geom.kh));
    assign stat.rem_zero = (rc_reg == '0) && (rr_reg == '0);
    assign stat.mac_last = (mi_reg == geom.kh - K_W'(1)) && (ni_reg == geom.kw - K_W'(1));
    assign m_data        = m_data_reg;

endmodule

// ----- src/depthwise_conv_bias_relu.sv -----
// A pixel request runs memory read, window shift, position divide (8 steps), stride check,
// serial tap MAC, drain, post and output; the next request is taken once the result is
// loaded, later still while the output stalls. A pixel whose window leaves the plane returns
// to idle after the window shift, one off the stride grid after the stride check; weight and
// bias loads finish in idle. One request is in work at a time. Reset (synchronous, active low)
// restores config defaults, clears taps, bias, window and position counters, not line memory.
// Top level: configuration registers, controller and datapath. Depends on dcbr_pkg.
module depthwise_conv_bias_relu
    import dcbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [DIM_W-1:0] in_width_reg, in_height_reg;
    logic [K_W-1:0]   kernel_w_reg, kernel_h_reg, stride_w_reg, stride_h_reg;
    logic             fuse_bias_reg, fuse_relu_reg;
    geom_t            geom;
    ctrl_cmd_t        cmd;
    ctrl_stat_t       stat;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg  <= DIM_W'(8);
            in_height_reg <= DIM_W'(8);
            kernel_w_reg  <= K_W'(3);
            kernel_h_reg  <= K_W'(3);
            stride_w_reg  <= K_W'(1);
            stride_h_reg  <= K_W'(1);
            fuse_bias_reg <= 1'b0;
            fuse_relu_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IN_WIDTH:  in_width_reg  <= cfg_wr_data;
                REG_IN_HEIGHT: in_height_reg <= cfg_wr_data;
                REG_KERNEL_W:  kernel_w_reg  <= cfg_wr_data[K_W-1:0];
                REG_KERNEL_H:  kernel_h_reg  <= cfg_wr_data[K_W-1:0];
                REG_STRIDE_W:  stride_w_reg  <= cfg_wr_data[K_W-1:0];
                REG_STRIDE_H:  stride_h_reg  <= cfg_wr_data[K_W-1:0];
                REG_FUSE_BIAS: fuse_bias_reg <= cfg_wr_data[0];
                REG_FUSE_RELU: fuse_relu_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Effective geometry after clamping.
    always_comb begin
        geom.w         = clamp_dim(in_width_reg, DIM_W'(MAX_WIDTH));
        geom.h         = clamp_dim(in_height_reg, DIM_W'(MAX_HEIGHT));
        geom.kw        = clamp_k(kernel_w_reg, K_W'(MAX_KERNEL));
        geom.kh        = clamp_k(kernel_h_reg, K_W'(MAX_KERNEL));
        geom.sw        = clamp_k(stride_w_reg, K_W'(7));
        geom.sh        = clamp_k(stride_h_reg, K_W'(7));
        geom.fuse_bias = fuse_bias_reg;
        geom.fuse_relu = fuse_relu_reg;
    end

    dcbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dcbr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule
